// ----- src/ball_follow_wheel_controller_unit_macros.svh -----
// Assertion macros for the ball follower block.
// No dependencies; included by the top level.
`ifndef BALL_FOLLOW_WHEEL_CONTROLLER_UNIT_MACROS_SVH
`define BALL_FOLLOW_WHEEL_CONTROLLER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BFW_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BFW_ASSERT(label, prop)
`define BFW_ASSERT_RST(label, prop)
`endif
`endif

// ----- src/bfw_pkg.sv -----
// Shared types and constants of the ball follower block.
// No dependencies.
package bfw_pkg;
  localparam int unsigned CB = 12;
  localparam logic [1:0] MODE_TRACK  = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam logic [2:0] REG_WIDTH = 3'd0, REG_TARGET = 3'd1, REG_DEAD = 3'd2,
    REG_TIMEOUT = 3'd3, REG_SIGN = 3'd4, REG_DGAIN = 3'd5, REG_SGAIN = 3'd6,
    REG_SEARCH = 3'd7;

  typedef struct packed {
    logic        op;
    logic [11:0] ball_x;
    logic [19:0] ball_area;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [1:0]         mode;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_O, ST_LOAD_R, ST_DIV_R, ST_MIX1, ST_MIX2, ST_MIX3, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch request, start decision
    logic div_start; // load divider
    logic div_sel;   // 0 orientation, 1 area ratio
    logic div_save;  // capture quotient
    logic mix1;
    logic mix2;
    logic mix3;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic track;     // tracking path needed
    logic div_done;
  } status_t;
endpackage

// ----- src/bfw_ctrl.sv -----
// Sequencer of the ball follower block.
// Depends on bfw_pkg.
module bfw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  output logic             res_valid_o,
  input  logic             res_stall_i,
  input  bfw_pkg::status_t sts_i,
  output bfw_pkg::cmd_t    cmd_o
);
  import bfw_pkg::*;
  state_e st_q, st_d;
  logic   vld_q, vld_d;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (req_valid_i && !req_stall_o) begin
        if (!sts_i.tick) st_d = ST_IDLE;
        else if (sts_i.track) st_d = ST_DIV_O;
        else st_d = ST_OUT;
      end
      ST_DIV_O: if (sts_i.div_done) st_d = ST_LOAD_R;
      ST_LOAD_R: st_d = ST_DIV_R;
      ST_DIV_R: if (sts_i.div_done) st_d = ST_MIX1;
      ST_MIX1: st_d = ST_MIX2;
      ST_MIX2: st_d = ST_MIX3;
      ST_MIX3: st_d = ST_OUT;
      ST_OUT: if (!vld_q || !res_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    req_stall_o = (st_q != ST_IDLE);
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.take = req_valid_i;
        cmd_o.div_start = req_valid_i;
        cmd_o.div_sel = 1'b0;
      end
      ST_DIV_O: begin
        cmd_o.div_sel = 1'b0;
        cmd_o.div_save = sts_i.div_done;
      end
      // reload the divider with the area ratio operands
      ST_LOAD_R: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_DIV_R: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_save = sts_i.div_done;
      end
      ST_MIX1: cmd_o.mix1 = 1'b1;
      ST_MIX2: cmd_o.mix2 = 1'b1;
      ST_MIX3: cmd_o.mix3 = 1'b1;
      ST_OUT:  cmd_o.emit = !vld_q || !res_stall_i;
      default: cmd_o = '0;
    endcase
  end

  // result valid: set on emit, drop when taken
  always_comb begin
    vld_d = vld_q;
    if (vld_q && !res_stall_i) vld_d = 1'b0;
    if (cmd_o.emit) vld_d = 1'b1;
  end
  assign res_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      vld_q <= vld_d;
    end
  end
endmodule

// ----- src/bfw_div.sv -----
// Restoring divider, one quotient bit a cycle, 33-bit dividend.
// Depends on bfw_pkg.
module bfw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [19:0] den_i,
  output logic        done_o,
  output logic [32:0] quo_o
);
  import bfw_pkg::*;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] q_q, q_d;
  logic [20:0] r_q, r_d;
  logic [19:0] den_q, den_d;
  logic [20:0] sh;

  // shift in one bit, subtract when it fits
  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; q_d = q_q; r_d = r_q; den_d = den_q;
    sh = {r_q[19:0], q_q[32]};
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 6'd33; q_d = num_i; r_d = '0; den_d = den_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q}; q_d = {q_q[31:0], 1'b1};
      end else begin
        r_d = sh; q_d = {q_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end
  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_o = q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end
endmodule

// ----- src/bfw_dp.sv -----
// Datapath of the ball follower: state, divider operands, speed mixing.
// Depends on bfw_pkg and bfw_div.
module bfw_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfw_pkg::in_item_t req_i,
  input  logic [11:0]       width_i,
  input  logic [19:0]       target_i,
  input  logic [11:0]       dead_i,
  input  logic [15:0]       timeout_i,
  input  logic              sign_i,
  input  logic [14:0]       dgain_i,
  input  logic [14:0]       sgain_i,
  input  logic [15:0]       search_i,
  input  bfw_pkg::cmd_t     cmd_i,
  output bfw_pkg::status_t  sts_o,
  output bfw_pkg::out_item_t res_o
);
  import bfw_pkg::*;
  logic [11:0] lx_q;
  logic [19:0] la_q;
  logic        seen_q, sr_q;
  logic [15:0] age_q, age_inc;
  logic [12:0] dmag;
  logic        dneg;
  logic [32:0] num;
  logic [19:0] den;
  logic        ddone;
  logic [32:0] quo;
  logic [12:0] om_q, rat_q;
  logic [12:0] om_eff;
  logic [15:0] v1_q, omg_q, v2_q;
  logic [28:0] p1;
  logic [27:0] p2;
  logic [12:0] slow;
  logic [25:0] p3;
  logic signed [17:0] l_s, r_s, l_c, r_c, s_neg;
  out_item_t   res_q;
  logic        stop, track;

  assign age_inc = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
  assign stop  = (target_i != '0) && (la_q >= target_i);
  assign track = seen_q && (age_inc <= timeout_i) && !stop;
  assign sts_o.tick = (req_i.op == OP_TICK);
  assign sts_o.track = track;
  assign sts_o.div_done = ddone;

  // offset |2x - w|
  always_comb begin
    logic [12:0] x2;
    x2 = {lx_q, 1'b0};
    dneg = x2 < {1'b0, width_i};
    dmag = dneg ? {1'b0, width_i} - x2 : x2 - {1'b0, width_i};
  end

  // divider operands: orientation then area ratio
  always_comb begin
    if (!cmd_i.div_sel) begin
      num = {8'd0, dmag, 12'd0};
      den = {8'd0, width_i};
    end else begin
      num = {1'b0, la_q, 12'd0};
      den = target_i;
    end
  end

  bfw_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .done_o(ddone), .quo_o(quo)
  );

  // detection and tick state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0; la_q <= '0; seen_q <= 1'b0; age_q <= '0; sr_q <= 1'b1;
    end else if (cmd_i.take) begin
      if (req_i.op == OP_DETECT) begin
        lx_q <= req_i.ball_x; la_q <= req_i.ball_area; seen_q <= 1'b1;
        age_q <= '0; sr_q <= ({req_i.ball_x, 1'b0} >= {1'b0, width_i});
      end else begin
        age_q <= age_inc;
      end
    end
  end

  // capture quotients, clamped to one
  assign om_eff = (width_i == '0 || dmag < {dead_i, 1'b0}) ? 13'd0 : om_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save && !cmd_i.div_sel)
      om_q <= (quo > 33'd4096) ? 13'd4096 : quo[12:0];
    if (cmd_i.div_save && cmd_i.div_sel)
      rat_q <= (target_i == '0) ? 13'd0 : ((quo > 33'd4096) ? 13'd4096 : quo[12:0]);
  end

  // mixing stages, one multiply each
  assign p1 = dgain_i * (13'd4096 - rat_q);
  assign p2 = sgain_i * om_eff;
  assign slow = (om_eff[12:1] > 12'd3072) ? 13'd1024 : 13'd4096 - {1'b0, om_eff[12:1]};
  assign p3 = v1_q[13:0] * slow[11:0] + (slow[12] ? {v1_q[13:0], 12'd0} : 26'd0);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mix1) v1_q <= (p1[28:12] > 17'd8192) ? 16'd8192 : p1[27:12];
    if (cmd_i.mix2) omg_q <= (p2[27:12] > 16'd4096) ? 16'd4096 : p2[27:12];
    if (cmd_i.mix3) v2_q <= {2'd0, p3[25:12]};
  end

  // wheel speeds
  always_comb begin
    logic signed [17:0] om_s;
    om_s = ((dneg ^ sign_i) && om_eff != '0) ? -$signed({2'b0, omg_q})
                                              : $signed({2'b0, omg_q});
    l_s = $signed({2'b0, v2_q}) - om_s;
    r_s = $signed({2'b0, v2_q}) + om_s;
    l_c = (l_s > 18'sd8192) ? 18'sd8192 : l_s;
    r_c = (r_s > 18'sd8192) ? 18'sd8192 : r_s;
    if (sign_i) l_c = -l_c;
    s_neg = -$signed({{2{search_i[15]}}, search_i});
    if (s_neg > 18'sd32767) s_neg = 18'sd32767;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!(seen_q && age_q <= timeout_i)) begin
        res_q.mode <= MODE_SEARCH;
        if (sr_q) begin
          res_q.right_speed <= search_i; res_q.left_speed <= s_neg[15:0];
        end else begin
          // spin the other way; the most negative speed saturates on negation
          res_q.right_speed <= s_neg[15:0];
          res_q.left_speed <= (search_i == 16'h8000) ? 16'h8001 : search_i;
        end
      end else if (stop) begin
        res_q.mode <= MODE_STOP; res_q.left_speed <= '0; res_q.right_speed <= '0;
      end else begin
        res_q.mode <= MODE_TRACK;
        res_q.left_speed <= l_c[15:0]; res_q.right_speed <= r_c[15:0];
      end
    end
  end
  assign res_o = res_q;
endmodule

// ----- src/ball_follow_wheel_controller_unit.sv -----
// Top level of the ball follower: APB registers, sequencer and datapath.
// Depends on bfw_pkg, bfw_ctrl, bfw_dp and the macros header.
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    in_item_t
//  res      out        res_valid/stall    out_item_t
//  apb      in         psel/penable       32-bit registers
//
// A detection is taken in the idle state and gives no result. A search or stop
// tick goes from idle straight to the output state, its result registered. A
// tracking tick runs two 33-step divisions in one shared divider
// with a reload state between them, three multiply stages and the output
// state. Reset clears the state and loads the registers with their defaults.
// A stalled result holds in its register; a tick waits behind it.
`include "ball_follow_wheel_controller_unit_macros.svh"
module ball_follow_wheel_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  bfw_pkg::in_item_t  req_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output bfw_pkg::out_item_t res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bfw_pkg::*;
  logic [11:0] width_q, dead_q;
  logic [19:0] target_q;
  logic [15:0] timeout_q, search_q;
  logic        sign_q;
  logic [14:0] dgain_q, sgain_q;
  cmd_t        cmd;
  status_t     sts;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640; target_q <= 20'd10000; dead_q <= 12'd20;
      timeout_q <= 16'd10; sign_q <= 1'b0; dgain_q <= 15'd4096;
      sgain_q <= 15'd4096; search_q <= 16'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_WIDTH:   width_q <= pwdata[11:0];
        REG_TARGET:  target_q <= pwdata[19:0];
        REG_DEAD:    dead_q <= pwdata[11:0];
        REG_TIMEOUT: timeout_q <= pwdata[15:0];
        REG_SIGN:    sign_q <= pwdata[0];
        REG_DGAIN:   dgain_q <= pwdata[14:0];
        REG_SGAIN:   sgain_q <= pwdata[14:0];
        REG_SEARCH:  search_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      REG_WIDTH:   prdata = {20'd0, width_q};
      REG_TARGET:  prdata = {12'd0, target_q};
      REG_DEAD:    prdata = {20'd0, dead_q};
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      REG_SIGN:    prdata = {31'd0, sign_q};
      REG_DGAIN:   prdata = {17'd0, dgain_q};
      REG_SGAIN:   prdata = {17'd0, sgain_q};
      REG_SEARCH:  prdata = {16'd0, search_q};
      default:     prdata = '0;
    endcase
  end

  bfw_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .res_valid_o, .res_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bfw_dp u_dp (
    .clk_i, .rst_ni, .req_i, .width_i(width_q), .target_i(target_q),
    .dead_i(dead_q), .timeout_i(timeout_q), .sign_i(sign_q),
    .dgain_i(dgain_q), .sgain_i(sgain_q), .search_i(search_q),
    .cmd_i(cmd), .sts_o(sts), .res_o(res_o)
  );

  `BFW_ASSERT(a_emit_once, cmd.emit |=> res_valid_o)
  `BFW_ASSERT(a_res_hold, res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o))
  `BFW_ASSERT_RST(a_rst_idle, !rst_ni |=> !res_valid_o && !req_stall_o)
endmodule

// ----- dv/tb_ball_follow_wheel_controller_unit.sv -----
// Testbench for the ball follower wheel controller: directed table, extremes, random requests.
// Depends on bfw_pkg and ball_follow_wheel_controller_unit; checks results against a predictor.
module tb_ball_follow_wheel_controller_unit;
  import bfw_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  in_item_t req_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  out_item_t res_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ball_follow_wheel_controller_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and state
  logic [11:0] cf_width;
  logic [19:0] cf_target;
  logic [11:0] cf_dead;
  logic [15:0] cf_timeout;
  logic        cf_sign;
  logic [14:0] cf_dgain, cf_sgain;
  logic signed [15:0] cf_search;
  logic [11:0] st_x;
  logic [19:0] st_area;
  logic        st_seen, st_right;
  logic [15:0] st_age;

  out_item_t wheel_q[$];
  int errors = 0, n_res = 0, n_ticks = 0, cycles = 0;
  int send_idle = 0, recv_stall = 0, phase = -1, hold_cnt = 0;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t r;
    logic [31:0] a, b;
    a = $urandom; b = $urandom;
    r.op = a[31]; r.ball_x = a[11:0]; r.ball_area = b[19:0];
    return r;
  endfunction

  // work out the wheel command caused by one request
  task automatic predict_wheels(input in_item_t it);
    out_item_t r;
    int s, l, rt, v, om, sl, orient, omag, onem;
    longint d2, dmag, q, prod;
    if (it.op == OP_DETECT) begin
      st_x = it.ball_x; st_area = it.ball_area; st_seen = 1; st_age = 0;
      st_right = (2 * int'(it.ball_x) >= int'(cf_width));
      return;
    end
    if (st_age != 16'hFFFF) st_age++;
    if (!st_seen || st_age > cf_timeout) begin
      s = st_right ? int'(cf_search) : -int'(cf_search);
      s = clampi(s, -32768, 32767);
      l = clampi(-s, -32768, 32767); rt = s; r.mode = MODE_SEARCH;
    end else if (cf_target != 0 && st_area >= cf_target) begin
      l = 0; rt = 0; r.mode = MODE_STOP;
    end else begin
      d2 = 2 * longint'(st_x) - longint'(cf_width);
      dmag = d2 < 0 ? -d2 : d2;
      orient = 0;
      if (cf_width != 0) begin
        q = (dmag * 4096) / cf_width;
        if (q > 4096) q = 4096;
        orient = d2 < 0 ? -int'(q) : int'(q);
      end
      if (dmag < 2 * longint'(cf_dead)) orient = 0;
      omag = orient < 0 ? -orient : orient;
      onem = 4096;
      if (cf_target != 0) begin
        q = (longint'(st_area) * 4096) / cf_target;
        if (q > 4096) q = 4096;
        onem = 4096 - int'(q);
      end
      v = clampi(int'((longint'(cf_dgain) * onem) >>> 12), 0, 8192);
      prod = (longint'(cf_sgain) * omag) >>> 12;
      om = orient < 0 ? -int'(prod) : int'(prod);
      if (cf_sign) om = -om;
      om = clampi(om, -4096, 4096);
      sl = 4096 - (omag >> 1);
      if (sl < 1024) sl = 1024;
      v = (v * sl) >>> 12;
      l = clampi(v - om, -8192, 8192);
      rt = clampi(v + om, -8192, 8192);
      if (cf_sign) l = -l;
      r.mode = MODE_TRACK;
    end
    r.left_speed = l[15:0]; r.right_speed = rt[15:0];
    wheel_q.push_back(r);
  endtask

  // apb write, setup then access phase
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_WIDTH:   cf_width = val[11:0];
      REG_TARGET:  cf_target = val[19:0];
      REG_DEAD:    cf_dead = val[11:0];
      REG_TIMEOUT: cf_timeout = val[15:0];
      REG_SIGN:    cf_sign = val[0];
      REG_DGAIN:   cf_dgain = val[14:0];
      REG_SGAIN:   cf_sgain = val[14:0];
      default:     cf_search = val[15:0];
    endcase
  endtask

  // offer one request and hold it until accepted; valid stays up for the next one
  task automatic send_req(input in_item_t it);
    @(negedge clk_i);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_valid_i <= 0;
      req_i <= rand_item();
      do @(negedge clk_i); while ($urandom_range(99) < send_idle);
    end
    req_valid_i <= 1; req_i <= it;
    do @(posedge clk_i); while (req_stall_o);
    predict_wheels(it);
  endtask

  // drop valid, wait until every expected result is in, then let the block settle
  task automatic drain;
    @(negedge clk_i);
    req_valid_i <= 0;
    req_i <= rand_item();
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      n_res++;
      if (wheel_q.size() == 0) begin
        errors++; $error("unexpected result %h", res_o);
      end else begin
        e = wheel_q.pop_front();
        if (res_o.left_speed !== e.left_speed) begin
          errors++; $error("left_speed exp %0d got %0d", e.left_speed, res_o.left_speed);
        end
        if (res_o.right_speed !== e.right_speed) begin
          errors++; $error("right_speed exp %0d got %0d", e.right_speed, res_o.right_speed);
        end
        if (res_o.mode !== e.mode) begin
          errors++; $error("mode exp %0d got %0d", e.mode, res_o.mode);
        end
      end
    end
  end

  // receiver stall, with one long hold-off early in the third phase
  always @(negedge clk_i) begin
    if (phase == 2 && hold_cnt < 400) begin
      res_stall_i <= 1; hold_cnt <= hold_cnt + 1;
    end else begin
      res_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  typedef struct {
    in_item_t it;
    logic chk;
    out_item_t res;
  } row_t;

  function automatic in_item_t mk(logic op, int x, int a);
    in_item_t r;
    r.op = op; r.ball_x = x[11:0]; r.ball_area = a[19:0];
    return r;
  endfunction

  function automatic out_item_t ok(int l, int r, logic [1:0] m);
    out_item_t o;
    o.left_speed = l[15:0]; o.right_speed = r[15:0]; o.mode = m;
    return o;
  endfunction

  initial begin
    row_t tbl[$];
    int w, ph;
    in_item_t it;
    cf_width = 640; cf_target = 10000; cf_dead = 20; cf_timeout = 10; cf_sign = 0;
    cf_dgain = 4096; cf_sgain = 4096; cf_search = 2048;
    st_x = 0; st_area = 0; st_seen = 0; st_age = 0; st_right = 1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;

    // directed table: reset search, stop, centre, extremes
    tbl.push_back('{mk(OP_TICK, 0, 0), 1, ok(-2048, 2048, MODE_SEARCH)});
    tbl.push_back('{mk(OP_DETECT, 320, 20000), 0, '0});
    tbl.push_back('{mk(OP_TICK, 4095, 1048575), 1, ok(0, 0, MODE_STOP)});
    tbl.push_back('{mk(OP_DETECT, 320, 0), 0, '0});
    tbl.push_back('{mk(OP_TICK, 0, 0), 1, ok(4096, 4096, MODE_TRACK)});
    tbl.push_back('{mk(OP_DETECT, 0, 0), 0, '0});
    tbl.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    tbl.push_back('{mk(OP_DETECT, 4095, 9999), 0, '0});
    tbl.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    tbl.push_back('{mk(OP_DETECT, 330, 10000), 0, '0});
    tbl.push_back('{mk(OP_TICK, 0, 0), 1, ok(0, 0, MODE_STOP)});
    tbl.push_back('{mk(OP_DETECT, 100, 5000), 0, '0});
    for (int i = 0; i < 11; i++) tbl.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    foreach (tbl[i]) begin
      send_req(tbl[i].it);
      if (tbl[i].chk && wheel_q.size() != 0 && wheel_q[$] !== tbl[i].res) begin
        errors++; $error("row %0d table exp %h pred %h", i, tbl[i].res, wheel_q[$]);
      end
    end
    drain();

    // zero width, zero target, all registers at extremes
    write_reg(REG_WIDTH, 0); write_reg(REG_TARGET, 0); write_reg(REG_DEAD, 0);
    write_reg(REG_TIMEOUT, 0); write_reg(REG_SIGN, 1); write_reg(REG_DGAIN, 32767);
    write_reg(REG_SGAIN, 32767); write_reg(REG_SEARCH, 32'hFFFF8000);
    send_req(mk(OP_DETECT, 5, 1048575)); send_req(mk(OP_TICK, 0, 0));
    send_req(mk(OP_TICK, 0, 0));
    drain();

    // random phases over several settings and idling mixes
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      w = (ph == 7) ? 4095 : $urandom_range(1, 4095);
      write_reg(REG_WIDTH, ph == 3 ? 1 : w);
      write_reg(REG_TARGET, ph == 5 ? 1048575 : $urandom_range(0, 1048575));
      write_reg(REG_DEAD, ph == 6 ? 4095 : $urandom_range(0, 100));
      write_reg(REG_TIMEOUT, ph == 4 ? 65535 : $urandom_range(0, 12));
      write_reg(REG_SIGN, ph[0]);
      write_reg(REG_DGAIN, $urandom_range(0, 32767));
      write_reg(REG_SGAIN, $urandom_range(0, 32767));
      write_reg(REG_SEARCH, $urandom);
      phase = ph;
      for (int k = 0; k < 140; k++) begin
        it = rand_item();
        it.op = ($urandom_range(2) != 0) ? OP_TICK : OP_DETECT;
        if ($urandom_range(3) != 0) begin
          it.ball_x = 12'($urandom_range(0, int'(cf_width)));
          if (cf_target != 0)
            it.ball_area = 20'($urandom_range(0, int'(cf_target) + int'(cf_target) / 4));
        end
        if (it.op == OP_TICK) n_ticks++;
        send_req(it);
      end
      drain();
    end

    $display("Ran directed and %0d random requests (%0d ticks) over 8 register settings;",
             ph * 140, n_ticks);
    $display("%0d results checked under idle, stall and long hold-off mixes.", n_res);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
